// ===== design/msprp_pkg.sv =====
// ----------------------------------------------------------------------------
// msprp_pkg
// shared constants and types for the msp v1 reply parser with telemetry
// ----------------------------------------------------------------------------
package msprp_pkg;

   // parser phase codes
   localparam logic [2:0] PH_HUNT    = 3'd0;
   localparam logic [2:0] PH_DOLLAR  = 3'd1;
   localparam logic [2:0] PH_EMM     = 3'd2;
   localparam logic [2:0] PH_LEN     = 3'd3;
   localparam logic [2:0] PH_CMD     = 3'd4;
   localparam logic [2:0] PH_PAYLOAD = 3'd5;
   localparam logic [2:0] PH_CHECK   = 3'd6;

   // preamble characters
   localparam logic [7:0] CHAR_DOLLAR = 8'h24;
   localparam logic [7:0] CHAR_M      = 8'h4D;
   localparam logic [7:0] CHAR_GT     = 8'h3E;
   localparam logic [7:0] CHAR_X      = 8'h58;

   // reply commands
   localparam logic [7:0] CMD_API_VERSION = 8'h02;
   localparam logic [7:0] CMD_STATUS      = 8'h65;
   localparam logic [7:0] CMD_BATTERY     = 8'h82;

   // minimum payload lengths for applied commands
   localparam logic [7:0] STATUS_MIN_LEN  = 8'd7;
   localparam logic [7:0] BATTERY_MIN_LEN = 8'd11;

   // payload positions kept for later use
   localparam logic [7:0] POS_CAP_LO  = 8'd4;
   localparam logic [7:0] POS_CAP_HI  = 8'd5;
   localparam logic [7:0] POS_FLAGS   = 8'd6;
   localparam logic [7:0] POS_VOLT_LO = 8'd9;
   localparam logic [7:0] POS_VOLT_HI = 8'd10;

   // register map
   localparam int         CSR_ADDR_W         = 3;
   localparam logic       REG_FRESH_WINDOW   = 1'b0;
   localparam logic       REG_VOLT_OVERRIDE  = 1'b1;
   localparam logic [15:0] FRESH_WINDOW_RST  = 16'd1000;
   localparam logic [15:0] VOLT_OVERRIDE_RST = 16'd1800;

   // one result, first field in the highest bit
   typedef struct packed {
      logic        v2_seen;
      logic        voltage_valid;
      logic        fc_present;
      logic [15:0] battery_mv;
      logic [15:0] capacity_x10;
      logic        armed;
      logic [7:0]  frame_command;
      logic        checksum_bad;
      logic        frame_ok;
   } result_type;

   localparam int RESULT_W = $bits(result_type);
   localparam int RSP_W    = ((RESULT_W + 7) / 8) * 8;

   // times ten, wrapped to 16 bits
   function automatic logic [15:0] times_ten(input logic [15:0] v);
      logic [15:0] a;
      logic [15:0] b;
      a = {v[12:0], 3'b000};
      b = {v[14:0], 1'b0};
      return a + b;
   endfunction

endpackage

// ===== design/msp_v1_reply_parser_telemetry_top.sv =====
// ----------------------------------------------------------------------------
// msp_v1_reply_parser_telemetry_top
// byte-wise msp v1 reply parser that latches arm, battery and freshness status
// ----------------------------------------------------------------------------
// Each request carries one received uart byte and the current time in ms. The
// byte advances a small parser that hunts for the '$','M','>' preamble, then
// takes length, command, payload and an xor checksum over length, command and
// payload. A good status reply (len >= 7) latches the arm bit, a good battery
// reply (len >= 11) latches capacity*10 and voltage*10 (16-bit wrap), and
// status, battery and api version replies stamp the receive time. Every
// request gives exactly one result, registered in the output register, with
// the frame flags, the latched values and the fresh/valid status as seen
// after that byte. A request is taken in every cycle the output register is
// empty or being drained, so the block runs at one byte per clock; the only
// thing that holds it back is the result side stalling. After a bad checksum
// the parser resumes hunting with the next byte. The two 16-bit registers
// (fresh window at 0x0, voltage override at 0x4) are written over the csr port
// and read back zero-extended.
// ----------------------------------------------------------------------------
module msp_v1_reply_parser_telemetry_top (
   input  logic                                 clock,
   input  logic                                 reset,
   // request channel
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   input  logic [39:0]                          req_tdata,   // rx_byte, now_ms
   // result channel
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   // frame_ok, checksum_bad, frame_command, armed, capacity_x10, battery_mv,
   // fc_present, voltage_valid, v2_seen, zero pad
   output logic [msprp_pkg::RSP_W-1:0]          rsp_tdata,
   // csr port
   input  logic                                 csr_psel,
   input  logic                                 csr_penable,
   input  logic                                 csr_pwrite,
   input  logic [msprp_pkg::CSR_ADDR_W-1:0]     csr_paddr,
   input  logic [31:0]                          csr_pwdata,
   output logic [31:0]                          csr_prdata,
   output logic                                 csr_pready
);

   // request fields
   logic [7:0]  rx_byte;
   logic [31:0] now_ms;
   logic        req_fire;

   // config registers
   logic [15:0] fresh_window_ff;
   logic [15:0] volt_override_ff;
   logic        csr_wr;

   // parser state
   logic [2:0]  phase_ff, phase_in;
   logic [7:0]  length_ff, length_in;
   logic [7:0]  command_ff, command_in;
   logic [7:0]  position_ff, position_in;
   logic [7:0]  xor_ff, xor_in;
   logic [7:0]  cap_lo_ff, cap_lo_in;
   logic [7:0]  cap_hi_ff, cap_hi_in;
   logic [7:0]  flags_ff, flags_in;
   logic [7:0]  volt_lo_ff, volt_lo_in;
   logic [7:0]  volt_hi_ff, volt_hi_in;

   // telemetry state
   logic        armed_ff, armed_in;
   logic [15:0] capacity_ff, capacity_in;
   logic [15:0] voltage_ff, voltage_in;
   logic [31:0] reply_time_ff, reply_time_in;
   logic [31:0] battery_time_ff, battery_time_in;
   logic        v2_ff, v2_in;

   // result register
   logic                     rsp_valid_ff, rsp_valid_in;
   msprp_pkg::result_type    result_ff, result_in;

   // per-byte scratch
   logic [7:0]  next_pos;
   logic [31:0] reply_age;
   logic [31:0] battery_age;

   assign rx_byte  = req_tdata[7:0];
   assign now_ms   = req_tdata[39:8];

   // output register frees up when empty or drained this cycle
   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign req_fire   = req_tvalid && req_tready;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(msprp_pkg::RSP_W - msprp_pkg::RESULT_W){1'b0}}, result_ff};

   // ---------------------------------------------------------------- csr port
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      unique case (csr_paddr[2])
         msprp_pkg::REG_FRESH_WINDOW:  csr_prdata = {16'b0, fresh_window_ff};
         msprp_pkg::REG_VOLT_OVERRIDE: csr_prdata = {16'b0, volt_override_ff};
         default:                      csr_prdata = 32'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fresh_window_ff  <= msprp_pkg::FRESH_WINDOW_RST;
         volt_override_ff <= msprp_pkg::VOLT_OVERRIDE_RST;
      end else if (csr_wr) begin
         if (csr_paddr[2] == msprp_pkg::REG_FRESH_WINDOW) begin
            fresh_window_ff <= csr_pwdata[15:0];
         end else begin
            volt_override_ff <= csr_pwdata[15:0];
         end
      end
   end

   // ------------------------------------------------------------ byte parser
   always_comb begin
      phase_in        = phase_ff;
      length_in       = length_ff;
      command_in      = command_ff;
      position_in     = position_ff;
      xor_in          = xor_ff;
      cap_lo_in       = cap_lo_ff;
      cap_hi_in       = cap_hi_ff;
      flags_in        = flags_ff;
      volt_lo_in      = volt_lo_ff;
      volt_hi_in      = volt_hi_ff;
      armed_in        = armed_ff;
      capacity_in     = capacity_ff;
      voltage_in      = voltage_ff;
      reply_time_in   = reply_time_ff;
      battery_time_in = battery_time_ff;
      v2_in           = v2_ff;
      next_pos        = position_ff + 8'd1;

      result_in               = '0;

      unique case (phase_ff)
         msprp_pkg::PH_DOLLAR: begin
            if (rx_byte == msprp_pkg::CHAR_M) begin
               phase_in = msprp_pkg::PH_EMM;
            end else if (rx_byte == msprp_pkg::CHAR_X) begin
               // v2 preamble seen, stays sticky
               v2_in    = 1'b1;
               phase_in = msprp_pkg::PH_HUNT;
            end else if (rx_byte == msprp_pkg::CHAR_DOLLAR) begin
               phase_in = msprp_pkg::PH_DOLLAR;
            end else begin
               phase_in = msprp_pkg::PH_HUNT;
            end
         end
         msprp_pkg::PH_EMM: begin
            if (rx_byte == msprp_pkg::CHAR_GT) begin
               phase_in = msprp_pkg::PH_LEN;
            end else if (rx_byte == msprp_pkg::CHAR_DOLLAR) begin
               phase_in = msprp_pkg::PH_DOLLAR;
            end else begin
               phase_in = msprp_pkg::PH_HUNT;
            end
         end
         msprp_pkg::PH_LEN: begin
            length_in = rx_byte;
            xor_in    = rx_byte;
            phase_in  = msprp_pkg::PH_CMD;
         end
         msprp_pkg::PH_CMD: begin
            command_in  = rx_byte;
            xor_in      = xor_ff ^ rx_byte;
            position_in = 8'd0;
            phase_in    = (length_ff == 8'd0) ? msprp_pkg::PH_CHECK : msprp_pkg::PH_PAYLOAD;
         end
         msprp_pkg::PH_PAYLOAD: begin
            // keep only the payload bytes the applied commands look at
            if (position_ff == msprp_pkg::POS_CAP_LO)  cap_lo_in  = rx_byte;
            if (position_ff == msprp_pkg::POS_CAP_HI)  cap_hi_in  = rx_byte;
            if (position_ff == msprp_pkg::POS_FLAGS)   flags_in   = rx_byte;
            if (position_ff == msprp_pkg::POS_VOLT_LO) volt_lo_in = rx_byte;
            if (position_ff == msprp_pkg::POS_VOLT_HI) volt_hi_in = rx_byte;
            xor_in      = xor_ff ^ rx_byte;
            position_in = next_pos;
            if (next_pos >= length_ff) begin
               phase_in = msprp_pkg::PH_CHECK;
            end
         end
         msprp_pkg::PH_CHECK: begin
            result_in.frame_command = command_ff;
            if (xor_ff == rx_byte) begin
               result_in.frame_ok = 1'b1;
               priority if (command_ff == msprp_pkg::CMD_STATUS &&
                            length_ff >= msprp_pkg::STATUS_MIN_LEN) begin
                  armed_in      = flags_ff[0];
                  reply_time_in = now_ms;
               end else if (command_ff == msprp_pkg::CMD_BATTERY &&
                            length_ff >= msprp_pkg::BATTERY_MIN_LEN) begin
                  capacity_in     = msprp_pkg::times_ten({cap_hi_ff, cap_lo_ff});
                  voltage_in      = msprp_pkg::times_ten({volt_hi_ff, volt_lo_ff});
                  reply_time_in   = now_ms;
                  battery_time_in = now_ms;
               end else if (command_ff == msprp_pkg::CMD_API_VERSION) begin
                  reply_time_in = now_ms;
               end
            end else begin
               result_in.checksum_bad = 1'b1;
            end
            phase_in = msprp_pkg::PH_HUNT;
         end
         default: begin
            // hunting for the dollar sign
            phase_in = (rx_byte == msprp_pkg::CHAR_DOLLAR) ? msprp_pkg::PH_DOLLAR
                                                           : msprp_pkg::PH_HUNT;
         end
      endcase

      // status after this byte, ages wrap modulo 2^32
      reply_age   = now_ms - reply_time_in;
      battery_age = now_ms - battery_time_in;

      result_in.armed         = armed_in;
      result_in.capacity_x10  = capacity_in;
      result_in.battery_mv    = voltage_in;
      result_in.fc_present    = (reply_time_in != 32'd0) &&
                                (reply_age <= {16'b0, fresh_window_ff});
      result_in.voltage_valid = (voltage_in > volt_override_ff) &&
                                (battery_age <= {16'b0, fresh_window_ff});
      result_in.v2_seen       = v2_in;
   end

   // result register valid
   always_comb begin
      if (req_fire) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff        <= msprp_pkg::PH_HUNT;
         length_ff       <= 8'd0;
         command_ff      <= 8'd0;
         position_ff     <= 8'd0;
         xor_ff          <= 8'd0;
         armed_ff        <= 1'b0;
         capacity_ff     <= 16'd0;
         voltage_ff      <= 16'd0;
         reply_time_ff   <= 32'd0;
         battery_time_ff <= 32'd0;
         v2_ff           <= 1'b0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (req_fire) begin
            phase_ff        <= phase_in;
            length_ff       <= length_in;
            command_ff      <= command_in;
            position_ff     <= position_in;
            xor_ff          <= xor_in;
            armed_ff        <= armed_in;
            capacity_ff     <= capacity_in;
            voltage_ff      <= voltage_in;
            reply_time_ff   <= reply_time_in;
            battery_time_ff <= battery_time_in;
            v2_ff           <= v2_in;
         end
      end
   end

   // payload registers, no reset
   always_ff @(posedge clock) begin
      if (req_fire) begin
         cap_lo_ff  <= cap_lo_in;
         cap_hi_ff  <= cap_hi_in;
         flags_ff   <= flags_in;
         volt_lo_ff <= volt_lo_in;
         volt_hi_ff <= volt_hi_in;
         result_ff  <= result_in;
      end
   end

   // ------------------------------------------------------------- assertions
   a_flags_exclusive: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(result_ff.frame_ok && result_ff.checksum_bad))
      else $error("frame_ok and checksum_bad both set");

   a_check_reports: assert property (@(posedge clock) disable iff (reset)
      (req_fire && phase_ff == msprp_pkg::PH_CHECK) |=>
         (rsp_valid_ff && (result_ff.frame_ok || result_ff.checksum_bad)))
      else $error("checksum byte gave no frame report");

   a_cmd_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !result_ff.frame_ok && !result_ff.checksum_bad) |->
         (result_ff.frame_command == 8'd0))
      else $error("frame_command set without a completed frame");

   a_v2_sticky: assert property (@(posedge clock) disable iff (reset)
      v2_ff |=> v2_ff)
      else $error("v2 flag cleared outside reset");

   a_hunt_after_check: assert property (@(posedge clock) disable iff (reset)
      (req_fire && phase_ff == msprp_pkg::PH_CHECK) |=>
         (phase_ff == msprp_pkg::PH_HUNT))
      else $error("parser did not return to hunting after checksum");

endmodule

// ===== tb/sv/msprp_telemetry_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// msprp_telemetry_checker
// watches the request, result and csr ports of the msp v1 reply parser,
// predicts every result from its own copy of parser state and registers,
// and compares each accepted result field by field with the oldest prediction
// ----------------------------------------------------------------------------
module msprp_telemetry_checker (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   input  logic                            req_tready,
   input  logic [39:0]                     req_tdata,   // rx_byte, now_ms
   input  logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   input  logic [msprp_pkg::RSP_W-1:0]     rsp_tdata,
   input  logic                            csr_psel,
   input  logic                            csr_penable,
   input  logic                            csr_pwrite,
   input  logic                            csr_pready,
   input  logic [msprp_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [31:0]                     csr_pwdata,
   output int                              failures,
   output int                              pending
);
   import msprp_pkg::*;

   // parser copy
   logic [2:0]  phase;
   logic [7:0]  plen;
   logic [7:0]  cmd_q;
   logic [7:0]  ppos;
   logic [7:0]  run_xor;
   logic [7:0]  kept [5];
   // telemetry latches
   logic        arm_q;
   logic [15:0] cap_q;
   logic [15:0] volt_q;
   logic [31:0] reply_t;
   logic [31:0] batt_t;
   logic        v2_q;
   // register copy
   logic [15:0] window_q;
   logic [15:0] override_q;

   result_type  predicted_status [$];
   result_type  got;
   result_type  want;

   function automatic result_type parse_byte(input logic [7:0] b, input logic [31:0] now);
      result_type  r;
      logic [31:0] age_reply;
      logic [31:0] age_batt;
      r = '0;
      case (phase)
         PH_DOLLAR: begin
            if (b == CHAR_M) begin
               phase = PH_EMM;
            end else if (b == CHAR_X) begin
               v2_q  = 1'b1;
               phase = PH_HUNT;
            end else begin
               phase = (b == CHAR_DOLLAR) ? PH_DOLLAR : PH_HUNT;
            end
         end
         PH_EMM: begin
            if (b == CHAR_GT)
               phase = PH_LEN;
            else
               phase = (b == CHAR_DOLLAR) ? PH_DOLLAR : PH_HUNT;
         end
         PH_LEN: begin
            plen    = b;
            run_xor = b;
            phase   = PH_CMD;
         end
         PH_CMD: begin
            cmd_q   = b;
            run_xor = run_xor ^ b;
            ppos    = 8'd0;
            phase   = (plen == 8'd0) ? PH_CHECK : PH_PAYLOAD;
         end
         PH_PAYLOAD: begin
            case (ppos)
               POS_CAP_LO:  kept[0] = b;
               POS_CAP_HI:  kept[1] = b;
               POS_FLAGS:   kept[2] = b;
               POS_VOLT_LO: kept[3] = b;
               POS_VOLT_HI: kept[4] = b;
               default: ;
            endcase
            run_xor = run_xor ^ b;
            ppos    = ppos + 8'd1;
            if (ppos >= plen)
               phase = PH_CHECK;
         end
         PH_CHECK: begin
            r.frame_command = cmd_q;
            if (run_xor == b) begin
               r.frame_ok = 1'b1;
               if (cmd_q == CMD_STATUS && plen >= STATUS_MIN_LEN) begin
                  arm_q   = kept[2][0];
                  reply_t = now;
               end else if (cmd_q == CMD_BATTERY && plen >= BATTERY_MIN_LEN) begin
                  // 16-bit context, so the product wraps
                  cap_q   = {kept[1], kept[0]} * 16'd10;
                  volt_q  = {kept[4], kept[3]} * 16'd10;
                  reply_t = now;
                  batt_t  = now;
               end else if (cmd_q == CMD_API_VERSION) begin
                  reply_t = now;
               end
            end else begin
               r.checksum_bad = 1'b1;
            end
            phase = PH_HUNT;
         end
         default: phase = (b == CHAR_DOLLAR) ? PH_DOLLAR : PH_HUNT;
      endcase
      age_reply       = now - reply_t;
      age_batt        = now - batt_t;
      r.armed         = arm_q;
      r.capacity_x10  = cap_q;
      r.battery_mv    = volt_q;
      r.fc_present    = (reply_t != 32'd0) && (age_reply <= {16'h0000, window_q});
      r.voltage_valid = (volt_q > override_q) && (age_batt <= {16'h0000, window_q});
      r.v2_seen       = v2_q;
      return r;
   endfunction

   task automatic check_field(input string name, input logic [31:0] want_v,
                              input logic [31:0] got_v);
      if (got_v !== want_v) begin
         $display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, want_v, got_v);
         failures++;
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         phase      = PH_HUNT;
         plen       = 8'd0;
         cmd_q      = 8'd0;
         ppos       = 8'd0;
         run_xor    = 8'd0;
         foreach (kept[i]) kept[i] = 8'd0;
         arm_q      = 1'b0;
         cap_q      = 16'd0;
         volt_q     = 16'd0;
         reply_t    = 32'd0;
         batt_t     = 32'd0;
         v2_q       = 1'b0;
         window_q   = FRESH_WINDOW_RST;
         override_q = VOLT_OVERRIDE_RST;
         predicted_status.delete();
         failures   = 0;
      end else begin
         if (rsp_tvalid === 1'b1 && rsp_tready) begin
            got = result_type'(rsp_tdata[RESULT_W-1:0]);
            if (predicted_status.size() == 0) begin
               $display("%0t: unexpected result, expected none, actual %h", $time, got);
               failures++;
            end else begin
               want = predicted_status.pop_front();
               check_field("frame_ok",      want.frame_ok,      got.frame_ok);
               check_field("checksum_bad",  want.checksum_bad,  got.checksum_bad);
               check_field("frame_command", want.frame_command, got.frame_command);
               check_field("armed",         want.armed,         got.armed);
               check_field("capacity_x10",  want.capacity_x10,  got.capacity_x10);
               check_field("battery_mv",    want.battery_mv,    got.battery_mv);
               check_field("fc_present",    want.fc_present,    got.fc_present);
               check_field("voltage_valid", want.voltage_valid, got.voltage_valid);
               check_field("v2_seen",       want.v2_seen,       got.v2_seen);
            end
         end
         if (req_tvalid && req_tready === 1'b1)
            predicted_status.push_back(parse_byte(req_tdata[7:0], req_tdata[39:8]));
         if (csr_psel && csr_penable && csr_pwrite && csr_pready === 1'b1) begin
            if ((csr_paddr >> 2) == REG_FRESH_WINDOW)
               window_q = csr_pwdata[15:0];
            else if ((csr_paddr >> 2) == REG_VOLT_OVERRIDE)
               override_q = csr_pwdata[15:0];
         end
      end
      pending = predicted_status.size();
   end

endmodule

// ===== tb/sv/tb_msp_v1_reply_parser_telemetry_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_msp_v1_reply_parser_telemetry_top
// stimulus and verdict for the msp v1 reply parser with telemetry latches:
// a short directed byte sequence, then random reply frames, broken preambles
// and noise over several register settings, with random stalls on both sides;
// the checker beside the block predicts and compares every result
// ----------------------------------------------------------------------------
module tb_msp_v1_reply_parser_telemetry_top;
   import msprp_pkg::*;

   localparam int ITEM_TARGET = 850;
   localparam int PHASES      = 8;

   logic                   clock;
   logic                   reset;
   logic                   req_tvalid;
   logic                   req_tready;
   logic [39:0]            req_tdata;   // rx_byte, now_ms
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   // frame_ok, checksum_bad, frame_command, armed, capacity_x10, battery_mv,
   // fc_present, voltage_valid, v2_seen, zero pad
   logic [RSP_W-1:0]       rsp_tdata;
   logic                   csr_psel;
   logic                   csr_penable;
   logic                   csr_pwrite;
   logic [CSR_ADDR_W-1:0]  csr_paddr;
   logic [31:0]            csr_pwdata;
   logic [31:0]            csr_prdata;
   logic                   csr_pready;

   int          failures;
   int          pending;
   int          sent = 0;
   int          hold_cnt = 0;
   bit          idle_on = 1'b1;        // random stalls allowed on both sides
   bit          clock_running = 1'b0;  // advance the ms timestamp per request
   logic [31:0] now_t = 32'd0;

   msp_v1_reply_parser_telemetry_top i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   msprp_telemetry_checker i_checker (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_pready  (csr_pready),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .failures    (failures),
      .pending     (pending)
   );

   // 100 MHz clock
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // watchdog, far beyond the slowest legal run
   initial begin
      #20_000_000;
      $display("tb_msp_v1_reply_parser_telemetry_top NOT OK");
      $finish;
   end

   // mostly short gaps, now and then a long one
   function automatic int pick_gap();
      int sel;
      sel = $urandom_range(0, 99);
      if (sel < 70)
         return $urandom_range(1, 3);
      if (sel < 95)
         return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   // timestamp walk: small steps, jumps past the fresh window, full random
   // values, and steps back so an age wraps to a huge number
   function automatic void step_time();
      int sel;
      sel = $urandom_range(0, 99);
      if (sel < 85)
         now_t = now_t + $urandom_range(0, 20);
      else if (sel < 93)
         now_t = now_t + $urandom_range(100, 1500);
      else if (sel < 97)
         now_t = $urandom;
      else
         now_t = now_t - $urandom_range(1, 50);
   endfunction

   // result side back-pressure
   always @(posedge clock) begin
      if (hold_cnt > 0) begin
         hold_cnt = hold_cnt - 1;
         rsp_tready <= 1'b0;
      end else if (idle_on && $urandom_range(0, 99) < 25) begin
         hold_cnt = pick_gap() - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // one request: optional idle gap, then hold valid until taken
   task automatic send_byte(input logic [7:0] b);
      int gap;
      gap = (idle_on && $urandom_range(0, 99) < 30) ? pick_gap() : 0;
      if (clock_running)
         step_time();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {now_t, b};
      @(posedge clock);
      while (req_tready !== 1'b1) @(posedge clock);
      sent++;
   endtask

   // full reply frame with random payload; corrupt flips checksum bits
   task automatic send_frame(input logic [7:0] cmd, input int len, input bit corrupt);
      logic [7:0] sum;
      logic [7:0] b;
      sum = 8'(len) ^ cmd;
      send_byte(CHAR_DOLLAR);
      send_byte(CHAR_M);
      send_byte(CHAR_GT);
      send_byte(8'(len));
      send_byte(cmd);
      for (int i = 0; i < len; i++) begin
         b   = 8'($urandom);
         sum = sum ^ b;
         send_byte(b);
      end
      if (corrupt)
         sum = sum ^ 8'($urandom_range(1, 255));
      send_byte(sum);
   endtask

   // frames mostly long enough to be applied, some short, rarely huge
   task automatic send_random_frame(input bit corrupt);
      logic [7:0] cmd;
      int         len;
      int         sel;
      sel = $urandom_range(0, 99);
      if (sel < 35)
         cmd = CMD_STATUS;
      else if (sel < 70)
         cmd = CMD_BATTERY;
      else if (sel < 85)
         cmd = CMD_API_VERSION;
      else
         cmd = 8'($urandom);
      sel = $urandom_range(0, 99);
      if (sel < 1)
         len = $urandom_range(200, 255);
      else if (sel < 18)
         len = $urandom_range(0, 10);
      else if (cmd == CMD_BATTERY)
         len = $urandom_range(11, 14);
      else if (cmd == CMD_STATUS)
         len = $urandom_range(7, 10);
      else
         len = $urandom_range(0, 8);
      send_frame(cmd, len, corrupt);
   endtask

   // one random chunk: good frame, bad checksum, broken preamble or noise
   task automatic random_item();
      int sel;
      int n;
      sel = $urandom_range(0, 99);
      if (sel < 70) begin
         send_random_frame(1'b0);
      end else if (sel < 80) begin
         send_random_frame(1'b1);
      end else if (sel < 88) begin
         send_byte(CHAR_DOLLAR);
         if ($urandom_range(0, 1)) begin
            send_byte(CHAR_X);
         end else begin
            send_byte(CHAR_M);
            send_byte(8'($urandom));
         end
      end else begin
         n = $urandom_range(1, 4);
         repeat (n) send_byte(($urandom_range(0, 4) == 0) ? CHAR_DOLLAR : 8'($urandom));
      end
   endtask

   // stop sending and wait until every predicted result has been taken
   task automatic wait_for_replies();
      req_tvalid <= 1'b0;
      @(posedge clock);
      wait (pending == 0);
   endtask

   // apb-style write: setup cycle, then access until pready
   task automatic csr_write(input int idx, input logic [15:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= CSR_ADDR_W'(idx * 4);
      csr_pwdata  <= {16'h0000, value};
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (csr_pready !== 1'b1) @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(posedge clock);
   endtask

   initial begin
      logic [15:0] window_v;
      logic [15:0] ovr_v;
      int          phase_end;
      int          mid;

      reset       <= 1'b1;
      req_tvalid  <= 1'b0;
      req_tdata   <= '0;
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      csr_paddr   <= '0;
      csr_pwdata  <= '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // directed part, timestamps set by hand
      now_t = 32'd0;
      send_byte(8'hFF);
      // v2 sighting
      send_byte(CHAR_DOLLAR);
      send_byte(CHAR_X);
      // broken preamble falls back to hunting
      send_byte(CHAR_DOLLAR);
      send_byte(CHAR_M);
      send_byte(8'h41);
      // broken preamble where the '$' restarts it, then a zero length api
      // version reply stamped at time zero, which never counts as present
      send_byte(CHAR_DOLLAR);
      send_byte(CHAR_M);
      send_frame(CMD_API_VERSION, 0, 1'b0);
      // reply at the top of the time range, then the counter wraps past it
      now_t = 32'hFFFF_FFFF;
      send_frame(CMD_API_VERSION, 0, 1'b0);
      now_t = 32'h0000_0005;
      send_byte(8'h00);
      // time before the stamp reads as a very old reply
      now_t = 32'hFFFF_FF00;
      send_byte(8'h7E);
      // status with zero length and a wrong checksum
      send_frame(CMD_STATUS, 0, 1'b1);

      // random part, one register setting per phase
      clock_running = 1'b1;
      for (int p = 0; p < PHASES; p++) begin
         case (p)
            0: begin
               window_v = FRESH_WINDOW_RST;
               ovr_v    = VOLT_OVERRIDE_RST;
            end
            1: begin
               window_v = 16'h0000;
               ovr_v    = 16'h0000;
            end
            2: begin
               window_v = 16'hFFFF;
               ovr_v    = 16'hFFFF;
            end
            3: begin
               window_v = 16'hFFFF;
               ovr_v    = 16'h0000;
            end
            4: begin
               window_v = 16'h0000;
               ovr_v    = 16'hFFFF;
            end
            default: begin
               window_v = 16'($urandom_range(0, 3000));
               ovr_v    = 16'($urandom);
            end
         endcase
         // registers only change with nothing in flight
         wait_for_replies();
         csr_write(REG_FRESH_WINDOW, window_v);
         csr_write(REG_VOLT_OVERRIDE, ovr_v);
         // some phases run with no stalls at all
         idle_on   = ($urandom_range(0, 3) != 0);
         phase_end = sent + ITEM_TARGET / PHASES;
         mid       = sent + ITEM_TARGET / (2 * PHASES);
         while (sent < mid) random_item();
         // sender holds off until the result side has caught up
         if (p % 2 == 0)
            wait_for_replies();
         while (sent < phase_end) random_item();
      end

      // drain, then let the clock run on to catch stray results
      wait_for_replies();
      repeat (5) @(posedge clock);
      if (failures == 0 && pending == 0)
         $display("tb_msp_v1_reply_parser_telemetry_top OK");
      else
         $display("tb_msp_v1_reply_parser_telemetry_top NOT OK");
      $finish;
   end

endmodule
